// ===== design/ipe_pkg.sv =====
// ----------------------------------------------------------------------------
// ipe_pkg: shared types and constants for the I/Q phase extract and unwrap
// CORDIC sizing, arctangent table, queue sizing and the angle record
// ----------------------------------------------------------------------------
package ipe_pkg;

  localparam int SAMPLE_WIDTH = 16;
  localparam int TURN_BITS    = 16;
  localparam int CORDIC_STEPS = 16;
  localparam int PHASE_WIDTH  = 32;
  // datapath width of the rotation registers, leaves room for the CORDIC gain
  localparam int CW           = SAMPLE_WIDTH + 4;
  // angle accumulator, 2^32 units per turn
  localparam int ZW           = 32;
  localparam int FIFO_DEPTH   = 32;
  localparam int FIFO_AW      = $clog2(FIFO_DEPTH);
  localparam int CREDIT_W     = $clog2(FIFO_DEPTH + 1);

  typedef logic signed [CW-1:0] cval_t;
  typedef logic [ZW-1:0]        zval_t;

  typedef struct packed {
    logic signed [TURN_BITS-1:0] raw;
    logic                        first;
  } angle_t;

  // atan(2^-k) in units of 2^-32 turn; steps past the table add nothing
  function automatic zval_t atan_lut(input int k);
    zval_t a;
    case (k)
      0:       a = 32'h20000000;
      1:       a = 32'h12E4051E;
      2:       a = 32'h09FB385B;
      3:       a = 32'h051111D4;
      4:       a = 32'h028B0D43;
      5:       a = 32'h0145D7E1;
      6:       a = 32'h00A2F61E;
      7:       a = 32'h00517C55;
      8:       a = 32'h0028BE53;
      9:       a = 32'h00145F2F;
      10:      a = 32'h000A2F98;
      11:      a = 32'h000517CC;
      12:      a = 32'h00028BE6;
      13:      a = 32'h000145F3;
      14:      a = 32'h0000A2FA;
      15:      a = 32'h0000517D;
      16:      a = 32'h000028BE;
      17:      a = 32'h0000145F;
      18:      a = 32'h00000A30;
      19:      a = 32'h00000518;
      20:      a = 32'h0000028C;
      21:      a = 32'h00000146;
      22:      a = 32'h000000A3;
      23:      a = 32'h00000051;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

// ===== design/ipe_cordic.sv =====
// ----------------------------------------------------------------------------
// ipe_cordic: pipelined vectoring CORDIC
// one micro-rotation per stage, angle rounded to the turn resolution at the end
// ----------------------------------------------------------------------------
module ipe_cordic (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  input  logic signed [ipe_pkg::SAMPLE_WIDTH-1:0] in_i,
  input  logic signed [ipe_pkg::SAMPLE_WIDTH-1:0] in_q,
  input  logic                                  in_first,
  output logic                                  out_valid,
  output ipe_pkg::angle_t                       out_angle
);

  localparam int N = ipe_pkg::CORDIC_STEPS;

  ipe_pkg::cval_t xs [0:N];
  ipe_pkg::cval_t ys [0:N];
  ipe_pkg::zval_t zs [0:N];
  logic           zero [0:N];
  logic           first [0:N];
  logic           vld [0:N];

  ipe_pkg::cval_t nx [0:N-1];
  ipe_pkg::cval_t ny [0:N-1];
  ipe_pkg::zval_t nz [0:N-1];

  ipe_pkg::cval_t xe;
  ipe_pkg::cval_t ye;
  ipe_pkg::zval_t zr;

  assign xe = ipe_pkg::CW'(in_i);
  assign ye = ipe_pkg::CW'(in_q);

  always_comb begin
    for (int k = 0; k < N; k++) begin
      if (ys[k] > 0) begin
        nx[k] = xs[k] + (ys[k] >>> k);
        ny[k] = ys[k] - (xs[k] >>> k);
        nz[k] = zs[k] + ipe_pkg::atan_lut(k);
      end else begin
        nx[k] = xs[k] - (ys[k] >>> k);
        ny[k] = ys[k] + (xs[k] >>> k);
        nz[k] = zs[k] - ipe_pkg::atan_lut(k);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= N; k++) begin
        vld[k] <= 1'b0;
      end
    end else begin
      vld[0] <= in_valid;
      for (int k = 0; k < N; k++) begin
        vld[k+1] <= vld[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    // left half plane: turn by half a turn first
    if (in_i < 0) begin
      xs[0] <= -xe;
      ys[0] <= -ye;
      zs[0] <= ipe_pkg::zval_t'(1) << (ipe_pkg::ZW - 1);
    end else begin
      xs[0] <= xe;
      ys[0] <= ye;
      zs[0] <= '0;
    end
    zero[0]  <= (in_i == 0) && (in_q == 0);
    first[0] <= in_first;
    for (int k = 0; k < N; k++) begin
      xs[k+1]    <= nx[k];
      ys[k+1]    <= ny[k];
      zs[k+1]    <= nz[k];
      zero[k+1]  <= zero[k];
      first[k+1] <= first[k];
    end
  end

  // round half up to the turn resolution, wrapping
  assign zr = zs[N] + (ipe_pkg::zval_t'(1) << (ipe_pkg::ZW - 1 - ipe_pkg::TURN_BITS));

  assign out_valid       = vld[N];
  assign out_angle.raw   = zero[N] ? '0 : zr[ipe_pkg::ZW-1 -: ipe_pkg::TURN_BITS];
  assign out_angle.first = first[N];

endmodule

// ===== design/ipe_fifo.sv =====
// ----------------------------------------------------------------------------
// ipe_fifo: angle queue between the CORDIC front and the unwrap back
// register-array queue, one write and one read port
// ----------------------------------------------------------------------------
module ipe_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  ipe_pkg::angle_t din,
  input  logic            pop,
  output logic            not_empty,
  output ipe_pkg::angle_t dout
);

  ipe_pkg::angle_t mem [0:ipe_pkg::FIFO_DEPTH-1];

  logic [ipe_pkg::FIFO_AW-1:0]  wr_ptr;
  logic [ipe_pkg::FIFO_AW-1:0]  rd_ptr;
  logic [ipe_pkg::CREDIT_W-1:0] count;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  assign not_empty = (count != '0);
  assign dout      = mem[rd_ptr];

endmodule

// ===== design/ipe_unwrap.sv =====
// ----------------------------------------------------------------------------
// ipe_unwrap: phase unwrap against the previous phase, with 32-bit clipping
// holds the previous unwrapped phase and the output register
// ----------------------------------------------------------------------------
module ipe_unwrap (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      in_valid,
  input  ipe_pkg::angle_t                           in_angle,
  output logic                                      pop,
  output logic                                      out_valid,
  input  logic                                      out_ready,
  output logic signed [ipe_pkg::TURN_BITS-1:0]      raw_angle,
  output logic signed [ipe_pkg::PHASE_WIDTH-1:0]    unwrapped_phase,
  output logic                                      saturated
);

  localparam int EW = ipe_pkg::PHASE_WIDTH + 4;
  localparam logic signed [EW-1:0] HALF     = EW'(64'sd1 <<< (ipe_pkg::TURN_BITS - 1));
  localparam logic signed [EW-1:0] TURN_M1  = EW'((64'sd1 <<< ipe_pkg::TURN_BITS) - 1);
  localparam logic signed [EW-1:0] TURN_MSK = ~TURN_M1;
  localparam logic signed [EW-1:0] PMAX     =
    EW'((64'sd1 <<< (ipe_pkg::PHASE_WIDTH - 1)) - 1);
  localparam logic signed [EW-1:0] PMIN     = EW'(-(64'sd1 <<< (ipe_pkg::PHASE_WIDTH - 1)));

  logic signed [ipe_pkg::PHASE_WIDTH-1:0] previous_phase;

  logic signed [EW-1:0] raw_e;
  logic signed [EW-1:0] prev_e;
  logic signed [EW-1:0] d;
  logic signed [EW-1:0] phase;
  logic signed [ipe_pkg::PHASE_WIDTH-1:0] phase_next;
  logic                 sat_next;

  assign pop = in_valid && (!out_valid || out_ready);

  always_comb begin
    raw_e  = EW'(in_angle.raw);
    prev_e = in_angle.first ? '0 : EW'(previous_phase);
    d      = raw_e - prev_e;
    phase  = raw_e;
    // whole turns of ceil(|d| / turn) pulled back towards the previous phase
    if (d > HALF) begin
      phase = raw_e - ((d + TURN_M1) & TURN_MSK);
    end else if (d < -HALF) begin
      phase = raw_e + ((TURN_M1 - d) & TURN_MSK);
    end
    if (phase > PMAX) begin
      phase_next = PMAX[ipe_pkg::PHASE_WIDTH-1:0];
      sat_next   = 1'b1;
    end else if (phase < PMIN) begin
      phase_next = PMIN[ipe_pkg::PHASE_WIDTH-1:0];
      sat_next   = 1'b1;
    end else begin
      phase_next = phase[ipe_pkg::PHASE_WIDTH-1:0];
      sat_next   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid      <= 1'b0;
      previous_phase <= '0;
    end else begin
      if (pop) begin
        out_valid      <= 1'b1;
        previous_phase <= phase_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      raw_angle       <= in_angle.raw;
      unwrapped_phase <= phase_next;
      saturated       <= sat_next;
    end
  end

endmodule

// ===== design/iq_phase_extract_unwrap.sv =====
// ----------------------------------------------------------------------------
// iq_phase_extract_unwrap: CORDIC atan2 of an I/Q stream with phase unwrap
// ----------------------------------------------------------------------------
// Input stream: one complex sample per transaction, s_tdata carries in_i and
// in_q, s_tuser flags the first sample of a signal (previous phase taken as 0).
// Output stream: one result per sample, in order: the wrapped CORDIC angle, the
// unwrapped phase (65536 units per turn) and a flag set when the phase clipped
// to 32 bits.
// From an accepted sample to its result on m_tvalid with an idle receiver, it
// passes 17 CORDIC register stages, the angle queue and the output register.
// Throughput: one sample per cycle unless the credits below run out; the phase
// unwrap forms each phase combinationally from the registered previous phase.
// The CORDIC pipeline never stalls. Sample acceptance is metered by credits
// equal to the 32-entry angle queue, so with a stalled receiver results pile up
// in the queue and s_tready drops once 32 samples are outstanding.
// Reset clears the previous phase to zero, empties the pipeline and the queue
// and drops m_tvalid; rst is synchronous, active high.
// ----------------------------------------------------------------------------
module iq_phase_extract_unwrap (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [15:0] in_i, [31:16] in_q
  input  logic [0:0]  s_tuser,   // [0] first_sample
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // [15:0] raw_angle, [47:16] unwrapped_phase
  output logic [0:0]  m_tuser    // [0] saturated
);

  logic                             s_take;
  logic [ipe_pkg::CREDIT_W-1:0]     credits;
  logic                             cordic_valid;
  ipe_pkg::angle_t                  cordic_angle;
  logic                             q_not_empty;
  ipe_pkg::angle_t                  q_angle;
  logic                             q_pop;
  logic signed [15:0]               raw_angle;
  logic signed [31:0]               unwrapped_phase;
  logic                             saturated;

  assign s_tready = (credits < ipe_pkg::CREDIT_W'(ipe_pkg::FIFO_DEPTH));
  assign s_take   = s_tvalid && s_tready;

  // samples in flight through the pipeline or waiting in the queue
  always_ff @(posedge clk) begin
    if (rst) begin
      credits <= '0;
    end else if (s_take && !q_pop) begin
      credits <= credits + 1'b1;
    end else if (q_pop && !s_take) begin
      credits <= credits - 1'b1;
    end
  end

  ipe_cordic u_cordic (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_take),
    .in_i      (s_tdata[15:0]),
    .in_q      (s_tdata[31:16]),
    .in_first  (s_tuser[0]),
    .out_valid (cordic_valid),
    .out_angle (cordic_angle)
  );

  ipe_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (cordic_valid),
    .din       (cordic_angle),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .dout      (q_angle)
  );

  ipe_unwrap u_unwrap (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (q_not_empty),
    .in_angle        (q_angle),
    .pop             (q_pop),
    .out_valid       (m_tvalid),
    .out_ready       (m_tready),
    .raw_angle       (raw_angle),
    .unwrapped_phase (unwrapped_phase),
    .saturated       (saturated)
  );

  assign m_tdata = {unwrapped_phase, raw_angle};
  assign m_tuser = saturated;

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the I/Q phase extract and unwrap block
// Drives I/Q samples with directed extremes, rotating ramps that unwrap through
// several turns both ways, and random samples under several sender idle and
// receiver stall patterns. A scoreboard predicts the CORDIC angle and the
// unwrapped phase of every accepted sample and checks each result transaction
// against it, in order.
// ----------------------------------------------------------------------------
module testbench;

  localparam int    CYCLE_LIMIT  = 1_000_000;
  localparam int    DRAIN_CYCLES = 40;
  localparam int    RAMP_LEAD    = 16;
  localparam int    RAMP_STEPS   = 48;
  localparam int    MAX_REPORTS  = 40;
  localparam longint TURN        = longint'(1) << ipe_pkg::TURN_BITS;
  localparam longint HALF_TURN   = longint'(1) << (ipe_pkg::TURN_BITS - 1);
  localparam longint PHASE_MAX   = 64'sd2147483647;
  localparam longint PHASE_MIN   = -64'sd2147483648;

  // atan(2^-k) in units of 2^-32 turn
  localparam bit [31:0] ATAN_TURNS [24] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  // eight directions, 45 degrees apart, counter-clockwise from the positive i axis
  localparam int RAMP_DI [8] = '{1, 1, 0, -1, -1, -1, 0, 1};
  localparam int RAMP_DQ [8] = '{0, 1, 1, 1, 0, -1, -1, -1};

  typedef struct packed {
    logic signed [ipe_pkg::TURN_BITS-1:0]   raw;
    logic signed [ipe_pkg::PHASE_WIDTH-1:0] phase;
    logic                                   sat;
  } phase_result_t;

  class unwrap_scoreboard;
    phase_result_t                          expected_phases[$];
    logic signed [ipe_pkg::PHASE_WIDTH-1:0] tracked_phase = '0;
    int unsigned                            mismatches = 0;

    function void report(string what);
      if (mismatches < MAX_REPORTS)
        $display("[%0t] mismatch: %s", $realtime, what);
      mismatches++;
    endfunction

    function int pending();
      return expected_phases.size();
    endfunction

    function logic signed [ipe_pkg::TURN_BITS-1:0] vector_angle(longint x, longint y);
      longint  dx;
      longint  dy;
      bit [31:0] z;
      bit [31:0] r;
      int      k;
      z = '0;
      if (x == 0 && y == 0)
        return '0;
      // left half plane: turn by half a turn first
      if (x < 0) begin
        x = -x;
        y = -y;
        z = 32'h8000_0000;
      end
      for (k = 0; k < ipe_pkg::CORDIC_STEPS; k++) begin
        dx = y >>> k;
        dy = x >>> k;
        if (y > 0) begin
          x += dx;
          y -= dy;
          z += (k < 24) ? ATAN_TURNS[k] : 32'd0;
        end else begin
          x -= dx;
          y += dy;
          z -= (k < 24) ? ATAN_TURNS[k] : 32'd0;
        end
      end
      r = z + (32'd1 << (31 - ipe_pkg::TURN_BITS));
      return r[31 -: ipe_pkg::TURN_BITS];
    endfunction

    function void note_sample(logic signed [ipe_pkg::SAMPLE_WIDTH-1:0] i,
                              logic signed [ipe_pkg::SAMPLE_WIDTH-1:0] q, logic first);
      longint        raw;
      longint        prev;
      longint        d;
      longint        n;
      longint        ph;
      phase_result_t e;
      raw  = vector_angle(longint'(i), longint'(q));
      prev = first ? 64'sd0 : longint'(tracked_phase);
      d    = raw - prev;
      ph   = raw;
      if (d > HALF_TURN) begin
        n  = (d + TURN - 1) >>> ipe_pkg::TURN_BITS;
        ph = raw - n * TURN;
      end
      if (d < -HALF_TURN) begin
        n  = (-d + TURN - 1) >>> ipe_pkg::TURN_BITS;
        ph = raw + n * TURN;
      end
      e.sat = 1'b0;
      if (ph > PHASE_MAX) begin
        ph    = PHASE_MAX;
        e.sat = 1'b1;
      end else if (ph < PHASE_MIN) begin
        ph    = PHASE_MIN;
        e.sat = 1'b1;
      end
      tracked_phase = ph[ipe_pkg::PHASE_WIDTH-1:0];
      e.raw   = raw[ipe_pkg::TURN_BITS-1:0];
      e.phase = ph[ipe_pkg::PHASE_WIDTH-1:0];
      expected_phases.push_back(e);
    endfunction

    function void check_result(logic [47:0] data, logic sat);
      phase_result_t e;
      if (expected_phases.size() == 0) begin
        report($sformatf("result with nothing expected, raw %0d phase %0d",
                         $signed(data[15:0]), $signed(data[47:16])));
        return;
      end
      e = expected_phases.pop_front();
      if (data[15:0] !== e.raw)
        report($sformatf("raw_angle %0d, expected %0d", $signed(data[15:0]), e.raw));
      if (data[47:16] !== e.phase)
        report($sformatf("unwrapped_phase %0d, expected %0d",
                         $signed(data[47:16]), e.phase));
      if (sat !== e.sat)
        report($sformatf("saturated %0b, expected %0b", sat, e.sat));
    endfunction
  endclass

  logic        clk;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata  = '0;
  logic [0:0]  s_tuser  = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic [0:0]  m_tuser;

  int unsigned sender_idle_pct = 0;
  int unsigned sink_stall_pct  = 0;
  int unsigned cycle_count     = 0;

  unwrap_scoreboard sb = new;

  iq_phase_extract_unwrap u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // both sides sampled at the edge, before any update lands
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready)
        sb.note_sample(s_tdata[15:0], s_tdata[31:16], s_tuser[0]);
      if (m_tvalid && m_tready)
        sb.check_result(m_tdata, m_tuser[0]);
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("** iq_phase_extract_unwrap: FAILED **");
    $finish;
  end

  task automatic push_sample(input logic signed [15:0] i, input logic signed [15:0] q,
                             input logic first);
    if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      s_tvalid <= 1'b0;
      do
        @(posedge clk);
      while ($urandom_range(99) < sender_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {q, i};
    s_tuser  <= first;
    do
      @(posedge clk);
    while (!s_tready);
  endtask

  // a lead-in that unwraps as far as two turns, upwards when rising and downwards
  // otherwise, then turns the other way and unwraps back through zero
  task automatic run_ramp(input bit rising);
    int dir;
    int idx;
    int s;
    int m;
    idx = 0;
    dir = rising ? 1 : -1;
    for (s = 0; s < RAMP_STEPS; s++) begin
      if (s == RAMP_LEAD)
        dir = -dir;
      m = $urandom_range(32767, 1024);
      push_sample(16'(RAMP_DI[idx] * m), 16'(RAMP_DQ[idx] * m), s == 0);
      idx = (idx + dir + 8) % 8;
    end
  endtask

  task automatic run_random(input int count);
    int              n;
    int unsigned     kind;
    logic signed [15:0] i;
    logic signed [15:0] q;
    for (n = 0; n < count; n++) begin
      kind = $urandom_range(9);
      i = 16'($urandom);
      q = 16'($urandom);
      if (kind >= 6 && kind < 8) begin
        // tiny vectors, near the origin the angle is coarse
        i = 16'(int'($urandom_range(8)) - 4);
        q = 16'(int'($urandom_range(8)) - 4);
      end else if (kind == 8) begin
        q = '0;
      end else if (kind == 9) begin
        i = '0;
      end
      push_sample(i, q, $urandom_range(15) == 0);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // extremes, axes, the zero vector and the exact half turn
    push_sample(16'sd32767, 16'sd0, 1'b1);
    push_sample(-16'sd32768, 16'sd0, 1'b0);
    push_sample(16'sd0, 16'sd32767, 1'b0);
    push_sample(16'sd0, -16'sd32768, 1'b0);
    push_sample(-16'sd32768, -16'sd32768, 1'b0);
    push_sample(16'sd32767, 16'sd32767, 1'b0);
    push_sample(-16'sd32768, 16'sd32767, 1'b0);
    push_sample(16'sd32767, -16'sd32768, 1'b0);
    push_sample(16'sd0, 16'sd0, 1'b1);
    push_sample(-16'sd1, 16'sd0, 1'b0);
    push_sample(16'sd1, 16'sd0, 1'b0);
    push_sample(16'sd0, 16'sd1, 1'b0);
    push_sample(16'sd0, -16'sd1, 1'b0);
    push_sample(-16'sd1, -16'sd1, 1'b0);
    // crossing the negative i axis both ways unwraps up and down
    push_sample(-16'sd20000, 16'sd10000, 1'b0);
    push_sample(-16'sd20000, -16'sd10000, 1'b0);
    push_sample(-16'sd20000, 16'sd10000, 1'b0);
    push_sample(-16'sd20000, -16'sd10000, 1'b1);
    push_sample(-16'sd1, 16'sd1, 1'b0);
    push_sample(-16'sd1, -16'sd1, 1'b0);
    push_sample(16'sd0, 16'sd0, 1'b0);

    run_ramp(1'b1);
    run_ramp(1'b0);
    run_random(300);

    sender_idle_pct = 73;
    run_random(300);
    sender_idle_pct = 0;
    sink_stall_pct  = 73;
    run_random(300);
    sender_idle_pct = 36;
    sink_stall_pct  = 36;
    run_random(300);

    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.pending() != 0)
      sb.report($sformatf("%0d results never arrived", sb.pending()));
    if (sb.mismatches == 0) begin
      $display("** iq_phase_extract_unwrap: PASSED **");
    end else begin
      $display("** iq_phase_extract_unwrap: FAILED **");
    end
    $finish;
  end

endmodule
